[design/rtlpm_pkg.sv]
`default_nettype none
package rtlpm_pkg;
    localparam int unsigned AddrW = 32;
    localparam int unsigned PfxW  = 6;
    localparam int unsigned MetW  = 16;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_SETDEF = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_PFX   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_ROUTE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [AddrW-1:0] network;
        logic [PfxW-1:0]  prefix;
        logic [AddrW-1:0] next_hop;
        logic [AddrW-1:0] iface;
        logic [MetW-1:0]  metric;
    } t_route;

    typedef struct packed {
        logic [2:0]       action;
        logic [AddrW-1:0] net_addr;
        logic [7:0]       prefix_length;
        logic [AddrW-1:0] hop_addr;
        logic [AddrW-1:0] iface_addr;
        logic [MetW-1:0]  route_cost;
        logic [AddrW-1:0] dest_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [AddrW-1:0] found_network;
        logic [PfxW-1:0]  found_prefix;
        logic [AddrW-1:0] found_next_hop;
        logic [AddrW-1:0] found_iface;
        logic [MetW-1:0]  found_metric;
    } t_rsp;

    // Per-cell command broadcast along the row
    typedef struct packed {
        logic   load;     // write entry at wr_idx with route
        logic   shift;    // cells at or above sh_idx take neighbor's entry
        t_route route;
    } t_cell_cmd;

    function automatic logic [AddrW-1:0] mask_of(input logic [PfxW-1:0] p);
        logic [AddrW-1:0] m;
        if (p == '0) m = '0;
        else if (p >= PfxW'(32)) m = '1;
        else m = ~({AddrW{1'b1}} >> p);
        return m;
    endfunction
endpackage
`default_nettype wire

[design/rtlpm_if.sv]
`default_nettype none
interface rtlpm_req_if;
    logic            valid;
    logic            ready;
    rtlpm_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtlpm_rsp_if;
    logic            valid;
    logic            ready;
    rtlpm_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/rtlpm_cell.sv]
`default_nettype none
// One table slot; holds a route and, during a scan, passes it one place toward slot 0.
module rtlpm_cell (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic               i_take,
    input  wire rtlpm_pkg::t_route  i_route,
    input  wire rtlpm_pkg::t_route  i_neighbor,
    output rtlpm_pkg::t_route       o_route
);
    rtlpm_pkg::t_route r_route;
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_route <= i_route;
        end else if (i_take) begin
            r_route <= i_neighbor;
        end
    end
    assign o_route = r_route;
endmodule
`default_nettype wire

[design/route_table_longest_prefix_match_unit.sv]
`default_nettype none
// Route table of up to ENTRIES routes kept in a row of cells, with add, remove,
// longest-prefix lookup, set-default and clear; one request is worked on at a time.
// Add, remove, lookup and set-default rotate the whole row once past slot 0, one
// slot per cycle, and then pass to the finish state, where the result is registered
// and offered; the next request is accepted only after that finish state. Clear and
// the unused action codes skip the rotation and go straight to the finish state.
// An update of an existing route is applied as it passes slot 0. An append is
// written into the tail slot at the step that brings it home to slot count. A
// remove shifts the later routes down by one in the finish cycle after the rotation.
// The result has its own register, so the next request is taken while a result
// waits. A request stalls in its finish cycle only while the previous result is
// still not taken. Change metric_ceiling only while no request is in flight.
module route_table_longest_prefix_match_unit #(
    parameter int unsigned ENTRIES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rtlpm_req_if.sink                 i_req,
    rtlpm_rsp_if.source               o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata
);
    localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    rtlpm_pkg::t_req    r_req;
    logic [CntW-1:0]    r_count, n_count;
    logic               r_dflt, n_dflt;
    logic [15:0]        r_ceil;
    logic [IdxW:0]      r_step;
    logic               r_hit, r_have, r_dfound;
    logic [IdxW-1:0]    r_hit_idx;
    logic [5:0]         r_best_pfx;
    logic [15:0]        r_best_met;
    rtlpm_pkg::t_route  r_best, r_dbest;
    rtlpm_pkg::t_rsp    r_rsp, n_rsp;
    logic               r_rsp_valid;

    rtlpm_pkg::t_route  w_cell [ENTRIES];
    rtlpm_pkg::t_route  w_head, w_new, w_app_route, w_pick;
    logic               w_rot, w_head_valid, w_match, w_exact;
    logic               w_is_add, w_full, w_bad_pfx, w_add_ok, w_app;
    logic               w_fin, w_shift, w_scan_act;
    logic [31:0]        w_mask;
    logic [2:0]         w_act;
    logic [5:0]         w_pfx6;
    logic [31:0]        w_net;
    logic [IdxW:0]      w_last;

    assign w_rot  = (r_state == S_SCAN);
    assign w_last = (IdxW+1)'(ENTRIES - 1);
    assign w_head = w_cell[0];
    assign w_act  = r_req.action;
    assign w_net  = (w_act == rtlpm_pkg::ACT_SETDEF) ? 32'd0 : r_req.net_addr;
    assign w_pfx6 = (w_act == rtlpm_pkg::ACT_SETDEF) ? 6'd0 : r_req.prefix_length[5:0];
    assign w_head_valid = (r_step < (IdxW+1)'(r_count)) && (r_step < (IdxW+1)'(ENTRIES));
    assign w_mask  = rtlpm_pkg::mask_of(w_head.prefix);
    assign w_match = w_head_valid
                   && ((r_req.dest_addr & w_mask) == (w_head.network & w_mask));
    assign w_exact = w_head_valid && (w_head.network == w_net)
                   && (r_req.prefix_length[7:6] == 2'b00 || w_act == rtlpm_pkg::ACT_SETDEF)
                   && (w_head.prefix == w_pfx6);

    assign w_is_add  = (w_act == rtlpm_pkg::ACT_ADD) || (w_act == rtlpm_pkg::ACT_SETDEF);
    assign w_full    = (r_count == CntW'(ENTRIES));
    assign w_bad_pfx = (w_act == rtlpm_pkg::ACT_ADD) && (r_req.prefix_length > 8'd32);
    assign w_add_ok  = w_is_add && !w_full && !w_bad_pfx;
    assign w_app     = w_rot && w_add_ok && !r_hit && (r_step == (IdxW+1)'(r_count));
    assign w_fin     = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);
    assign w_shift   = w_fin && (w_act == rtlpm_pkg::ACT_REMOVE) && r_hit;
    assign w_pick    = r_have ? r_best : r_dbest;

    assign w_scan_act = (i_req.payload.action == rtlpm_pkg::ACT_ADD)
                      || (i_req.payload.action == rtlpm_pkg::ACT_REMOVE)
                      || (i_req.payload.action == rtlpm_pkg::ACT_LOOKUP)
                      || (i_req.payload.action == rtlpm_pkg::ACT_SETDEF);

    always_comb begin
        w_app_route.network  = w_net;
        w_app_route.prefix   = w_pfx6;
        w_app_route.next_hop = r_req.hop_addr;
        w_app_route.iface    = (w_act == rtlpm_pkg::ACT_SETDEF) ? 32'd0 : r_req.iface_addr;
        w_app_route.metric   = (w_act == rtlpm_pkg::ACT_SETDEF) ? 16'd1 : r_req.route_cost;
    end

    always_comb begin
        w_new = w_head;
        if (w_rot && w_add_ok && w_exact && !r_hit) begin
            w_new.next_hop = w_app_route.next_hop;
            w_new.iface    = w_app_route.iface;
            w_new.metric   = w_app_route.metric;
        end
    end

    // tail takes the head back (or the appended route); remove shifts the upper part down
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_row
            rtlpm_pkg::t_route w_nb;
            logic w_ld, w_tk;
            assign w_tk = w_rot || (w_shift && (IdxW'(g) >= r_hit_idx));
            if (g == ENTRIES - 1) begin : g_tail
                assign w_nb = w_new;
                assign w_ld = w_app;
            end else begin : g_mid
                assign w_nb = w_cell[g+1];
                assign w_ld = 1'b0;
            end
            rtlpm_cell u_cell (
                .i_clk      (i_clk),
                .i_load     (w_ld),
                .i_take     (w_tk),
                .i_route    (w_app_route),
                .i_neighbor (w_nb),
                .o_route    (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dflt      <= 1'b0;
            r_ceil      <= 16'hFFFF;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_ceil <= i_cfg_wdata;
            r_state <= n_state;
            r_count <= n_count;
            r_dflt  <= n_dflt;
            if (w_fin) r_rsp_valid <= 1'b1;
            else if (o_rsp.ready) r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req    <= i_req.payload;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_have   <= 1'b0;
            r_dfound <= 1'b0;
            r_best_pfx <= '0;
            r_best_met <= r_ceil;
        end else if (r_state == S_SCAN) begin
            r_step <= r_step + 1'b1;
            if (w_match && (w_head.prefix > r_best_pfx ||
                    (w_head.prefix == r_best_pfx && w_head.metric < r_best_met))) begin
                r_have <= 1'b1;
                r_best <= w_head;
                r_best_pfx <= w_head.prefix;
                r_best_met <= w_head.metric;
            end
            if (w_head_valid && w_head.prefix == '0 && !r_dfound) begin
                r_dfound <= 1'b1;
                r_dbest  <= w_head;
            end
            if (w_exact && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_step[IdxW-1:0];
            end
        end
        if (w_fin) r_rsp <= n_rsp;
    end

    always_comb begin
        n_rsp = '0;
        case (w_act)
            rtlpm_pkg::ACT_ADD, rtlpm_pkg::ACT_SETDEF: begin
                if (w_full) n_rsp.status = rtlpm_pkg::ST_FULL;
                else if (w_bad_pfx) n_rsp.status = rtlpm_pkg::ST_BAD_PFX;
                else n_rsp.status = rtlpm_pkg::ST_OK;
            end
            rtlpm_pkg::ACT_REMOVE: begin
                n_rsp.status = r_hit ? rtlpm_pkg::ST_OK : rtlpm_pkg::ST_NOT_FOUND;
            end
            rtlpm_pkg::ACT_LOOKUP: begin
                if (r_have || (r_dflt && r_dfound)) begin
                    n_rsp.status         = rtlpm_pkg::ST_OK;
                    n_rsp.found_network  = w_pick.network;
                    n_rsp.found_prefix   = w_pick.prefix;
                    n_rsp.found_next_hop = w_pick.next_hop;
                    n_rsp.found_iface    = w_pick.iface;
                    n_rsp.found_metric   = w_pick.metric;
                end else begin
                    n_rsp.status = rtlpm_pkg::ST_NO_ROUTE;
                end
            end
            default: n_rsp.status = rtlpm_pkg::ST_OK;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_dflt  = r_dflt;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = w_scan_act ? S_SCAN : S_DONE;
            S_SCAN:  if (r_step == w_last) n_state = S_DONE;
            S_DONE:  if (w_fin) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_fin) begin
            if (w_act == rtlpm_pkg::ACT_CLEAR) begin
                n_count = '0;
                n_dflt  = 1'b0;
            end else if (w_add_ok && !r_hit) begin
                n_count = r_count + CntW'(1);
                if (w_pfx6 == '0) n_dflt = 1'b1;
            end else if (w_shift) begin
                n_count = r_count - CntW'(1);
            end
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(ENTRIES));
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state));
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.payload));
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.payload.status <= rtlpm_pkg::ST_NO_ROUTE);
endmodule
`default_nettype wire

[tb/sv/route_table_longest_prefix_match_unit_tb.sv]
`default_nettype none
module route_table_longest_prefix_match_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES = 64;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    rtlpm_req_if req_ch ();
    rtlpm_rsp_if rsp_ch ();

    route_table_longest_prefix_match_unit #(.ENTRIES(ENTRIES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    rtlpm_pkg::t_route tbl_routes[ENTRIES];
    int unsigned tbl_count;
    bit          tbl_default;
    logic [15:0] tbl_ceiling;

    rtlpm_pkg::t_rsp rsp_expected[$];
    int unsigned fail_count;
    int unsigned sent_count;
    int unsigned rsp_count;
    int unsigned lookup_hits;
    longint      cycle_count;
    bit          idle_enable;
    bit          hold_rsp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t timeout", $time);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] prefix_mask(input int unsigned p);
        if (p == 0) return 32'h0;
        if (p >= 32) return 32'hFFFF_FFFF;
        return ~(32'hFFFF_FFFF >> p);
    endfunction

    function automatic logic [2:0] route_add(input logic [31:0] net, input int unsigned pfx,
                                             input logic [31:0] hop, input logic [31:0] ifc,
                                             input logic [15:0] cost);
        if (tbl_count >= ENTRIES) return rtlpm_pkg::ST_FULL;
        if (pfx > 32) return rtlpm_pkg::ST_BAD_PFX;
        for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_routes[i].network == net && 32'(tbl_routes[i].prefix) == pfx) begin
                tbl_routes[i].next_hop = hop;
                tbl_routes[i].iface    = ifc;
                tbl_routes[i].metric   = cost;
                return rtlpm_pkg::ST_OK;
            end
        end
        tbl_routes[tbl_count] = '{net, pfx[5:0], hop, ifc, cost};
        if (pfx == 0) tbl_default = 1'b1;
        tbl_count++;
        return rtlpm_pkg::ST_OK;
    endfunction

    function automatic rtlpm_pkg::t_rsp route_predict(input rtlpm_pkg::t_req r);
        rtlpm_pkg::t_rsp o;
        bit          have;
        int unsigned best;
        int unsigned best_pfx;
        int unsigned best_met;
        logic [31:0] m;
        o = '0;
        have = 0;
        best = 0;
        best_pfx = 0;
        best_met = 32'(tbl_ceiling);
        case (r.action)
            rtlpm_pkg::ACT_ADD: o.status = route_add(r.net_addr, 32'(r.prefix_length),
                                                     r.hop_addr, r.iface_addr, r.route_cost);
            rtlpm_pkg::ACT_SETDEF: o.status = route_add('0, 0, r.hop_addr, '0, 16'd1);
            rtlpm_pkg::ACT_CLEAR: begin
                tbl_count = 0;
                tbl_default = 0;
            end
            rtlpm_pkg::ACT_REMOVE: begin
                o.status = rtlpm_pkg::ST_NOT_FOUND;
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (tbl_routes[i].network == r.net_addr
                        && r.prefix_length == 8'(tbl_routes[i].prefix)) begin
                        for (int unsigned j = i; j + 1 < tbl_count; j++)
                            tbl_routes[j] = tbl_routes[j + 1];
                        tbl_count--;
                        o.status = rtlpm_pkg::ST_OK;
                        break;
                    end
                end
            end
            rtlpm_pkg::ACT_LOOKUP: begin
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    m = prefix_mask(32'(tbl_routes[i].prefix));
                    if ((r.dest_addr & m) == (tbl_routes[i].network & m)) begin
                        if (32'(tbl_routes[i].prefix) > best_pfx
                            || (32'(tbl_routes[i].prefix) == best_pfx
                            && 32'(tbl_routes[i].metric) < best_met)) begin
                            have = 1;
                            best = i;
                            best_pfx = 32'(tbl_routes[i].prefix);
                            best_met = 32'(tbl_routes[i].metric);
                        end
                    end
                end
                if (!have && tbl_default) begin
                    for (int unsigned i = 0; i < tbl_count; i++) begin
                        if (tbl_routes[i].prefix == 0) begin
                            have = 1;
                            best = i;
                            break;
                        end
                    end
                end
                if (have) begin
                    o.found_network  = tbl_routes[best].network;
                    o.found_prefix   = tbl_routes[best].prefix;
                    o.found_next_hop = tbl_routes[best].next_hop;
                    o.found_iface    = tbl_routes[best].iface;
                    o.found_metric   = tbl_routes[best].metric;
                    lookup_hits++;
                end else begin
                    o.status = rtlpm_pkg::ST_NO_ROUTE;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_req(input rtlpm_pkg::t_req r);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp_expected.push_back(route_predict(r));
        sent_count++;
    endtask

    // ready toggling and long hold-off
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_rsp = 0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        rtlpm_pkg::t_rsp exp_rsp;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_count++;
                if (rsp_expected.size() == 0) begin
                    $display("%0t unexpected response %p", $time, rsp_ch.payload);
                    fail_count++;
                end else begin
                    exp_rsp = rsp_expected.pop_front();
                    if (rsp_ch.payload !== exp_rsp) begin
                        $display("%0t mismatch expected %p actual %p", $time, exp_rsp,
                                 rsp_ch.payload);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic rtlpm_pkg::t_req mk_req(input rtlpm_pkg::t_action a,
                                               input logic [31:0] net,
                                               input logic [7:0] pfx, input logic [31:0] dst);
        rtlpm_pkg::t_req r;
        r.action        = a;
        r.net_addr      = net;
        r.prefix_length = pfx;
        r.hop_addr      = $urandom;
        r.iface_addr    = $urandom;
        r.route_cost    = 16'($urandom);
        r.dest_addr     = dst;
        return r;
    endfunction

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
    endtask

    task automatic write_ceiling(input logic [15:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tbl_ceiling = v;
    endtask

    task automatic test_directed();
        rtlpm_pkg::t_req r;
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'hFFFF_FFFF));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'h0A00_0000, 8, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'h0A01_0000, 16, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'hFFFF_FFFF, 32, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'h0A01_0000, 16, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'h1, 33, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 32'h1, 8'hFF, 0));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'h0A01_0203));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'hFFFF_FFFF));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'h0B00_0000));
        send_req(mk_req(rtlpm_pkg::ACT_SETDEF, 0, 0, 0));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'h0B00_0000));
        send_req(mk_req(rtlpm_pkg::ACT_REMOVE, 0, 0, 0));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'h0B00_0000));
        send_req(mk_req(rtlpm_pkg::ACT_REMOVE, 32'h0A00_0000, 40, 0));
        send_req(mk_req(rtlpm_pkg::ACT_REMOVE, 32'h0A00_0000, 8, 0));
        r = mk_req(rtlpm_pkg::ACT_ADD, 32'h0A01_0001, 16, 0);
        r.route_cost = 16'h0;
        send_req(r);
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 32'h0A01_9999));
        r = mk_req(rtlpm_pkg::t_action'(3'd5), $urandom, 8'($urandom), $urandom);
        send_req(r);
        r.action = rtlpm_pkg::t_action'(3'd7);
        send_req(r);
        send_req(mk_req(rtlpm_pkg::ACT_CLEAR, 0, 0, 0));
        for (int i = 0; i < ENTRIES; i++) send_req(mk_req(rtlpm_pkg::ACT_ADD, i, 32, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 0, 32, 0));
        send_req(mk_req(rtlpm_pkg::ACT_ADD, 1, 40, 0));
        send_req(mk_req(rtlpm_pkg::ACT_LOOKUP, 0, 0, 63));
        send_req(mk_req(rtlpm_pkg::ACT_CLEAR, 0, 0, 0));
    endtask

    task automatic test_random(input int n);
        rtlpm_pkg::t_req r;
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            r = mk_req(rtlpm_pkg::ACT_LOOKUP, $urandom, 8'($urandom_range(0, 32)), $urandom);
            if (k < 6) r.prefix_length = 8'($urandom);
            // small address pool makes exact matches and prefix hits common
            if (k % 3 != 0) begin
                r.net_addr = {8'($urandom_range(0, 3)), 24'h0} | ($urandom & 32'h0000_0F0F);
                r.dest_addr = {8'($urandom_range(0, 3)), 24'h0} | ($urandom & 32'h0000_0F0F);
                r.route_cost = 16'($urandom_range(0, 7));
            end
            if (k < 40) r.action = rtlpm_pkg::ACT_ADD;
            else if (k < 55) r.action = rtlpm_pkg::ACT_REMOVE;
            else if (k < 92) r.action = rtlpm_pkg::ACT_LOOKUP;
            else if (k < 96) r.action = rtlpm_pkg::ACT_SETDEF;
            else if (k < 98) r.action = rtlpm_pkg::ACT_CLEAR;
            else r.action = rtlpm_pkg::t_action'(3'($urandom_range(5, 7)));
            send_req(r);
        end
    endtask

    initial begin
        fail_count = 0;
        sent_count = 0;
        rsp_count = 0;
        lookup_hits = 0;
        tbl_count = 0;
        tbl_default = 0;
        tbl_ceiling = 16'hFFFF;
        idle_enable = 1;
        hold_rsp = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_ceiling(16'h0000);
        test_random(300);
        write_ceiling(16'h0004);
        hold_rsp = 1;
        test_random(400);
        write_ceiling(16'hFFFF);
        test_random(700);
        write_ceiling(16'h0003);
        test_random(200);
        write_ceiling(16'hFFFF);
        idle_enable = 0;
        test_random(250);
        drain();
        $display("Sent %0d requests, %0d responses, %0d lookup hits", sent_count, rsp_count,
                 lookup_hits);
        $display("Covered full table, bad prefixes, default fallback and several ceilings");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
